// ===== rtl/smi_pkg.sv =====
// Shared types and constants for the small matrix inverse block.
`default_nettype none
package smi_pkg;

  localparam int NLANE = 9;

  typedef enum logic [1:0] {
    ORD_NONE = 2'd0,
    ORD_1    = 2'd1,
    ORD_2    = 2'd2,
    ORD_3    = 2'd3
  } order_t;

  // Operands of the nine 2x2 cofactors: a*b - c*d, as row-major element indexes.
  localparam logic [3:0] XOP [NLANE][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage
`default_nettype wire

// ===== rtl/smi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, nine lanes sharing a divisor.
`default_nettype none
module smi_div #(
  parameter int QW  = 32,
  parameter int RW  = 165,
  parameter int DDW = 100,
  parameter int TW  = 120
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RW-1:0]         nn [smi_pkg::NLANE],
  input  logic [DDW-1:0]        dd,
  input  logic [TW-1:0]         tag_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [QW-1:0]         quo [smi_pkg::NLANE],
  output logic [smi_pkg::NLANE-1:0] ovf,
  output logic [TW-1:0]         tag_out
);
  import smi_pkg::*;

  logic              v      [QW];
  logic              rdy    [QW];
  logic [RW-1:0]     rem    [QW][NLANE];
  logic [QW-1:0]     qt     [QW][NLANE];
  logic [NLANE-1:0]  ov     [QW];
  logic [DDW-1:0]    dv     [QW];
  logic [TW-1:0]     tg     [QW];

  logic              v_src  [QW];
  logic [RW-1:0]     r_src  [QW][NLANE];
  logic [QW-1:0]     q_src  [QW][NLANE];
  logic [NLANE-1:0]  ov_src [QW];
  logic [DDW-1:0]    d_src  [QW];
  logic [TW-1:0]     t_src  [QW];

  logic [RW-1:0]     r_next [QW][NLANE];
  logic [QW-1:0]     q_next [QW][NLANE];
  logic [NLANE-1:0]  ov_next [QW];

  genvar g;
  generate
    for (g = 0; g < QW; g++) begin : g_rdy
      if (g == QW - 1) begin : g_last
        assign rdy[g] = !v[g] || !out_stall;
      end else begin : g_mid
        assign rdy[g] = !v[g] || rdy[g+1];
      end
    end
  endgenerate

  assign in_stall  = !rdy[0];
  assign out_valid = v[QW-1];
  assign quo       = qt[QW-1];
  assign ovf       = ov[QW-1];
  assign tag_out   = tg[QW-1];

  always_comb begin
    logic [RW-1:0] sh;
    logic [RW:0]   diff;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        v_src[k]  = in_valid;
        d_src[k]  = dd;
        t_src[k]  = tag_in;
        for (int l = 0; l < NLANE; l++) begin
          r_src[k][l] = nn[l];
          q_src[k][l] = '0;
        end
        ov_src[k] = '0;
      end else begin
        v_src[k]  = v[k-1];
        d_src[k]  = dv[k-1];
        t_src[k]  = tg[k-1];
        r_src[k]  = rem[k-1];
        q_src[k]  = qt[k-1];
        ov_src[k] = ov[k-1];
      end
    end
    for (int k = 0; k < QW; k++) begin
      ov_next[k] = ov_src[k];
      for (int l = 0; l < NLANE; l++) begin
        sh   = RW'(d_src[k]) << (QW - 1 - k);
        diff = {1'b0, r_src[k][l]} - {1'b0, sh};
        r_next[k][l] = diff[RW] ? r_src[k][l] : diff[RW-1:0];
        q_next[k][l] = q_src[k][l];
        q_next[k][l][QW-1-k] = !diff[RW];
        if (k == 0) begin
          ov_next[k][l] = r_src[k][l] >= (RW'(d_src[k]) << QW);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) v[k] <= 1'b0;
    end else begin
      for (int k = 0; k < QW; k++) begin
        if (rdy[k]) v[k] <= v_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rdy[k] && v_src[k]) begin
        rem[k] <= r_next[k];
        qt[k]  <= q_next[k];
        ov[k]  <= ov_next[k];
        dv[k]  <= d_src[k];
        tg[k]  <= t_src[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v[0])
    else $error("divider stalls input with empty first stage");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tag_out))
    else $error("divider dropped a stalled item");
  a_move: assert property (@(posedge clk) disable iff (rst)
    !out_valid && v[0] && !in_valid |=> !in_stall)
    else $error("divider blocked with room to advance");
`endif

endmodule
`default_nettype wire

// ===== rtl/small_matrix_inverse.sv =====
// Small matrix inverse top level: determinant, adjugate and pipelined division.
//
// Input channel: in_valid/in_stall with nine signed fixed-point elements m00..m22,
// row-major. Only the top-left block of the configured order is used.
// Config: cfg_write/cfg_data set matrix_order (1, 2 or 3); a write of 0 is
// ignored. Write only while the pipeline is empty.
// Output channel: out_valid/out_stall with inv00..inv22, det_value, singular.
// One result per item, same order. Inverse lanes outside the active block are 0;
// a zero determinant gives singular=1 and all zero values.
// Pipeline: seven front stages (input register, products, cofactors, determinant
// partial products, determinant, magnitudes, dividend), one restoring-divider
// stage per quotient bit, one saturation stage.
// Throughput: one item per cycle while out_stall is low. Every stage holds its own
// valid bit, so an item is accepted while results wait at the output, until the
// pipe is full. When out_stall holds, the output stays and bubbles upstream are squeezed out.
// Reset clears all valid bits and sets matrix_order to 3.
`default_nettype none
module small_matrix_inverse #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRAC_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [ELEMENT_WIDTH-1:0] m00,
  input  logic signed [ELEMENT_WIDTH-1:0] m01,
  input  logic signed [ELEMENT_WIDTH-1:0] m02,
  input  logic signed [ELEMENT_WIDTH-1:0] m10,
  input  logic signed [ELEMENT_WIDTH-1:0] m11,
  input  logic signed [ELEMENT_WIDTH-1:0] m12,
  input  logic signed [ELEMENT_WIDTH-1:0] m20,
  input  logic signed [ELEMENT_WIDTH-1:0] m21,
  input  logic signed [ELEMENT_WIDTH-1:0] m22,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ELEMENT_WIDTH-1:0] inv00,
  output logic signed [ELEMENT_WIDTH-1:0] inv01,
  output logic signed [ELEMENT_WIDTH-1:0] inv02,
  output logic signed [ELEMENT_WIDTH-1:0] inv10,
  output logic signed [ELEMENT_WIDTH-1:0] inv11,
  output logic signed [ELEMENT_WIDTH-1:0] inv12,
  output logic signed [ELEMENT_WIDTH-1:0] inv20,
  output logic signed [ELEMENT_WIDTH-1:0] inv21,
  output logic signed [ELEMENT_WIDTH-1:0] inv22,
  output logic signed [ELEMENT_WIDTH-1:0] det_value,
  output logic                            singular
);
  import smi_pkg::*;

  localparam int W   = ELEMENT_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int CW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int DDW = DW + 1;
  localparam int RW  = 4 * W + 2 * F + 5;
  localparam int TW  = 2 * NLANE + 2 + DW;

  order_t matrix_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_order <= ORD_3;
    end else if (cfg_write && cfg_data != ORD_NONE) begin
      matrix_order <= order_t'(cfg_data);
    end
  end

  // valid bits and ready chain of the front stages
  logic v0, v1, v2, v3, v4, v5, v6;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic div_stall;

  assign rdy6 = !v6 || !div_stall;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // stage 0: input register
  logic signed [W-1:0] e0 [NLANE];
  order_t              o0;

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      e0 <= '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      o0 <= matrix_order;
    end
  end

  // stage 1: cofactor products
  logic signed [PW-1:0] p1 [2*NLANE];
  logic signed [W-1:0]  e1 [NLANE];
  order_t               o1;

  always_ff @(posedge clk) begin
    if (rdy1 && v0) begin
      for (int k = 0; k < NLANE; k++) begin
        p1[2*k]   <= e0[XOP[k][0]] * e0[XOP[k][1]];
        p1[2*k+1] <= e0[XOP[k][2]] * e0[XOP[k][3]];
      end
      e1 <= e0;
      o1 <= o0;
    end
  end

  // stage 2: cofactors and adjugate select
  logic signed [CW-1:0] cr     [NLANE];
  logic signed [CW-1:0] adj_n  [NLANE];
  logic [NLANE-1:0]     act_n;

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      cr[k]    = CW'(p1[2*k]) - CW'(p1[2*k+1]);
      adj_n[k] = '0;
    end
    act_n = '0;
    case (o1)
      ORD_1: begin
        adj_n[0] = CW'(1);
        act_n[0] = 1'b1;
      end
      ORD_2: begin
        adj_n[0] = CW'(e1[4]);
        adj_n[1] = -CW'(e1[1]);
        adj_n[3] = -CW'(e1[3]);
        adj_n[4] = CW'(e1[0]);
        act_n[0] = 1'b1;
        act_n[1] = 1'b1;
        act_n[3] = 1'b1;
        act_n[4] = 1'b1;
      end
      default: begin
        adj_n = cr;
        act_n = '1;
      end
    endcase
  end

  logic signed [CW-1:0] adj2 [NLANE];
  logic [NLANE-1:0]     act2;
  logic signed [CW-1:0] c22_2;
  logic signed [W-1:0]  row2 [3];
  order_t               o2;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      adj2  <= adj_n;
      act2  <= act_n;
      c22_2 <= cr[8];
      row2  <= '{e1[0], e1[1], e1[2]};
      o2    <= o1;
    end
  end

  // stage 3: determinant partial products, adjugate split in high and low halves
  logic signed [W:0]    hi2 [3];
  logic signed [W:0]    lo2 [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hi2[j] = adj2[3*j][CW-1:W];
      lo2[j] = $signed({1'b0, adj2[3*j][W-1:0]});
    end
  end

  logic signed [CW-1:0] ph3 [3];
  logic signed [CW-1:0] pl3 [3];
  logic signed [CW-1:0] adj3 [NLANE];
  logic [NLANE-1:0]     act3;
  logic signed [CW-1:0] c22_3;
  logic signed [W-1:0]  a00_3;
  order_t               o3;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int j = 0; j < 3; j++) begin
        ph3[j] <= row2[j] * hi2[j];
        pl3[j] <= row2[j] * lo2[j];
      end
      adj3  <= adj2;
      act3  <= act2;
      c22_3 <= c22_2;
      a00_3 <= row2[0];
      o3    <= o2;
    end
  end

  // stage 4: determinant
  logic signed [DW-1:0] det_n;

  always_comb begin
    case (o3)
      ORD_1: det_n = DW'(a00_3);
      ORD_2: det_n = DW'(c22_3);
      default: begin
        det_n = '0;
        for (int j = 0; j < 3; j++) begin
          det_n = det_n + (DW'(ph3[j]) <<< W) + DW'(pl3[j]);
        end
      end
    endcase
  end

  logic signed [DW-1:0] det4;
  logic signed [CW-1:0] adj4 [NLANE];
  logic [NLANE-1:0]     act4;
  order_t               o4;

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      det4 <= det_n;
      adj4 <= adj3;
      act4 <= act3;
      o4   <= o3;
    end
  end

  // stage 5: magnitudes and signs
  logic [DW-1:0]    dmag5;
  logic             dneg5;
  logic             zero5;
  logic [CW-1:0]    amag5 [NLANE];
  logic [NLANE-1:0] lneg5;
  logic [NLANE-1:0] act5;
  order_t           o5;

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      dmag5 <= det4[DW-1] ? DW'(-det4) : DW'(det4);
      dneg5 <= det4[DW-1];
      zero5 <= det4 == '0;
      for (int l = 0; l < NLANE; l++) begin
        amag5[l] <= adj4[l][CW-1] ? CW'(-adj4[l]) : CW'(adj4[l]);
        lneg5[l] <= adj4[l][CW-1] ^ det4[DW-1];
      end
      act5 <= act4;
      o5   <= o4;
    end
  end

  // stage 6: dividends, divisor, rounded determinant magnitude
  logic [DW-1:0] rmag_n;

  always_comb begin
    case (o5)
      ORD_1:   rmag_n = dmag5;
      ORD_2:   rmag_n = (dmag5 + (DW'(1) << (F - 1))) >> F;
      default: rmag_n = (dmag5 + (DW'(1) << (2 * F - 1))) >> (2 * F);
    endcase
  end

  logic [RW-1:0]  nn6 [NLANE];
  logic [DDW-1:0] dd6;
  logic [TW-1:0]  tag6;

  always_ff @(posedge clk) begin
    if (rdy6 && v5) begin
      for (int l = 0; l < NLANE; l++) begin
        nn6[l] <= (RW'(amag5[l]) << (2 * F + 1)) + RW'(dmag5);
      end
      dd6  <= {dmag5, 1'b0};
      tag6 <= {act5, lneg5, zero5, dneg5, rmag_n};
    end
  end

  // divider
  logic             dvalid;
  logic             dstall;
  logic [W-1:0]     dq [NLANE];
  logic [NLANE-1:0] dovf;
  logic [TW-1:0]    dtag;

  smi_div #(
    .QW (W),
    .RW (RW),
    .DDW(DDW),
    .TW (TW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v6),
    .in_stall (div_stall),
    .nn       (nn6),
    .dd       (dd6),
    .tag_in   (tag6),
    .out_valid(dvalid),
    .out_stall(dstall),
    .quo      (dq),
    .ovf      (dovf),
    .tag_out  (dtag)
  );

  // output stage: saturate, sign, mask
  logic             rdy_o;
  logic [NLANE-1:0] t_act;
  logic [NLANE-1:0] t_neg;
  logic             t_zero;
  logic             t_dneg;
  logic [DW-1:0]    t_rmag;

  assign rdy_o  = !out_valid || !out_stall;
  assign dstall = !rdy_o;
  assign {t_act, t_neg, t_zero, t_dneg, t_rmag} = dtag;

  logic [W-1:0]        lim_pos;
  logic [W-1:0]        lim_neg;
  logic signed [W-1:0] val_n [NLANE];
  logic signed [W-1:0] det_n_o;

  assign lim_pos = {1'b0, {(W-1){1'b1}}};
  assign lim_neg = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    logic [W-1:0] lim;
    logic [W-1:0] mag;
    for (int l = 0; l < NLANE; l++) begin
      lim = t_neg[l] ? lim_neg : lim_pos;
      mag = (dovf[l] || dq[l] > lim) ? lim : dq[l];
      if (t_zero || !t_act[l]) begin
        val_n[l] = '0;
      end else begin
        val_n[l] = t_neg[l] ? $signed(-mag) : $signed(mag);
      end
    end
    lim = t_dneg ? lim_neg : lim_pos;
    mag = (t_rmag > DW'(lim)) ? lim : t_rmag[W-1:0];
    det_n_o = t_dneg ? $signed(-mag) : $signed(mag);
  end

  logic signed [W-1:0] inv_q [NLANE];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_o) begin
      out_valid <= dvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && dvalid) begin
      inv_q     <= val_n;
      det_value <= det_n_o;
      singular  <= t_zero;
    end
  end

  assign inv00 = inv_q[0];
  assign inv01 = inv_q[1];
  assign inv02 = inv_q[2];
  assign inv10 = inv_q[3];
  assign inv11 = inv_q[4];
  assign inv12 = inv_q[5];
  assign inv20 = inv_q[6];
  assign inv21 = inv_q[7];
  assign inv22 = inv_q[8];

`ifndef SYNTHESIS
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> det_value == '0 && inv00 == '0 && inv11 == '0
      && inv22 == '0 && inv01 == '0 && inv10 == '0)
    else $error("singular result carries nonzero values");
  a_order_zero_ignored: assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_data == ORD_NONE |=> $stable(matrix_order))
    else $error("order register took a zero write");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v0 && v1)
    else $error("input stalled with room in the front stages");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_small_matrix_inverse.sv =====
// Self-checking testbench for small_matrix_inverse: random and directed matrices.
`default_nettype none
module tb_small_matrix_inverse;
  timeunit 1ns;
  timeprecision 1ps;
  import smi_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [31:0] elem_t;
  typedef struct {
    elem_t m [9];
  } matrix_t;
  typedef struct {
    elem_t inv [9];
    elem_t det;
    logic  sing;
  } inverse_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRESS_CYCLES   = 300;
  localparam int DRAIN_CYCLES   = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_data = ORD_NONE;
  logic out_valid;
  logic out_stall = 1'b0;
  elem_t drv [9] = '{default: '0};
  elem_t inv [9];
  elem_t det_value;
  logic singular;

  matrix_t pend_items [$];
  inverse_t expected_inverses [$];
  order_t order_now = ORD_3;
  int errors = 0;
  bit press_req = 0;
  bit quiet_in = 0;

  small_matrix_inverse DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .m00(drv[0]), .m01(drv[1]), .m02(drv[2]),
    .m10(drv[3]), .m11(drv[4]), .m12(drv[5]),
    .m20(drv[6]), .m21(drv[7]), .m22(drv[8]),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]),
    .inv10(inv[3]), .inv11(inv[4]), .inv12(inv[5]),
    .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
    .det_value(det_value), .singular(singular)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round to nearest, ties away from zero, saturate to 32 bits
  function automatic elem_t round_div(wide_t n, wide_t d);
    bit neg;
    wide_t mn, md, q, lim;
    neg = (n < 0) != (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    q = (2 * mn + md) / (2 * md);
    lim = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic wide_t xprod(wide_t a, wide_t b, wide_t c, wide_t d);
    return a * b - c * d;
  endfunction

  function automatic inverse_t invert_matrix(matrix_t x, order_t ord);
    inverse_t r;
    wide_t a [9];
    wide_t adj [9];
    wide_t det;
    int n;
    for (int i = 0; i < 9; i++) begin
      a[i] = wide_t'(x.m[i]);
      adj[i] = '0;
    end
    if (ord == ORD_1) begin
      n = 1;
      adj[0] = 1;
      det = a[0];
    end else if (ord == ORD_2) begin
      n = 2;
      adj[0] = a[4];
      adj[1] = -a[1];
      adj[3] = -a[3];
      adj[4] = a[0];
      det = xprod(a[0], a[4], a[1], a[3]);
    end else begin
      n = 3;
      adj[0] = xprod(a[4], a[8], a[5], a[7]);
      adj[1] = xprod(a[2], a[7], a[1], a[8]);
      adj[2] = xprod(a[1], a[5], a[2], a[4]);
      adj[3] = xprod(a[5], a[6], a[3], a[8]);
      adj[4] = xprod(a[0], a[8], a[2], a[6]);
      adj[5] = xprod(a[2], a[3], a[0], a[5]);
      adj[6] = xprod(a[3], a[7], a[4], a[6]);
      adj[7] = xprod(a[1], a[6], a[0], a[7]);
      adj[8] = xprod(a[0], a[4], a[1], a[3]);
      det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    end
    r.inv = '{default: '0};
    r.det = '0;
    r.sing = (det == 0);
    if (!r.sing) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          r.inv[i*3+j] = round_div(adj[i*3+j] <<< 32, det);
      r.det = round_div(det, wide_t'(1) <<< ((n - 1) * 16));
    end
    return r;
  endfunction

  // driver
  matrix_t cur;
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_inverses.push_back(invert_matrix(cur, order_now));
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pend_items.size() > 0) begin
          cur = pend_items.pop_front();
          drv <= cur.m;
          in_valid <= 1'b1;
          gap = quiet_in ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  int hold = 0;
  int press_cnt = 0;
  bit press_done = 0;
  bit quiet_out = 0;
  inverse_t exp_r;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_inverses.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          exp_r = expected_inverses.pop_front();
          for (int i = 0; i < 9; i++)
            if (inv[i] !== exp_r.inv[i]) begin
              $error("inv%0d%0d expected %0d actual %0d", i / 3, i % 3, exp_r.inv[i], inv[i]);
              errors++;
            end
          if (det_value !== exp_r.det) begin
            $error("det_value expected %0d actual %0d", exp_r.det, det_value);
            errors++;
          end
          if (singular !== exp_r.sing) begin
            $error("singular expected %0d actual %0d", exp_r.sing, singular);
            errors++;
          end
        end
        if ($urandom_range(0, 40) == 0) quiet_out = !quiet_out;
        hold = quiet_out ? 0 : $urandom_range(0, 9);
      end else if (hold > 0) begin
        hold--;
      end
      if (press_req && !press_done) begin
        press_cnt++;
        if (press_cnt >= PRESS_CYCLES) press_done = 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (hold > 0);
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic elem_t rand_elem();
    elem_t v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: v = '0;
      3: v = 32'sh7fffffff;
      4: v = 32'sh80000000;
      5, 6: v = ($urandom_range(0, 4) <<< 16) + $urandom_range(0, 65535);
      default: v = $urandom_range(0, 1 << 20);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t x;
    for (int i = 0; i < 9; i++) x.m[i] = rand_elem();
    // dependent rows give a zero determinant
    if ($urandom_range(0, 9) == 0)
      for (int j = 0; j < 3; j++) x.m[3 + j] = x.m[j];
    return x;
  endfunction

  function automatic matrix_t fill(elem_t v);
    matrix_t x;
    x.m = '{default: v};
    return x;
  endfunction

  task automatic load_directed();
    matrix_t x;
    x = fill('0);
    pend_items.push_back(x);
    x.m[0] = 32'sh10000; x.m[4] = 32'sh10000; x.m[8] = 32'sh10000;
    pend_items.push_back(x);
    x.m[0] = 1; x.m[4] = -1; x.m[8] = 1;
    pend_items.push_back(x);
    pend_items.push_back(fill(32'sh7fffffff));
    pend_items.push_back(fill(32'sh80000000));
    x = fill(32'sh80000000);
    x.m[1] = 32'sh7fffffff; x.m[5] = 32'sh7fffffff; x.m[6] = 32'sh7fffffff;
    x.m[4] = '0;
    pend_items.push_back(x);
    x = fill('0);
    x.m[0] = 32'sh7fffffff; x.m[4] = 32'sh80000000; x.m[8] = 32'sh7fffffff;
    x.m[1] = 32'sh8000; x.m[3] = -32'sh8000;
    pend_items.push_back(x);
    x = fill(32'sh20000);
    x.m[0] = 32'sh30000; x.m[4] = -32'sh18000; x.m[8] = 32'sh8000;
    pend_items.push_back(x);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pend_items.size() != 0 || in_valid || expected_inverses.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  logic [1:0] settings [5] = '{ORD_3, ORD_1, ORD_2, ORD_NONE, ORD_3};
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= settings[p];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (settings[p] != ORD_NONE) order_now = order_t'(settings[p]);
      end
      @(negedge clk);
      quiet_in = (p == 2);
      load_directed();
      for (int k = 0; k < 82; k++) pend_items.push_back(rand_matrix());
      if (p == 1) begin
        repeat (20) @(negedge clk);
        press_req = 1;
      end
      wait_idle();
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
